// ===== hdl/hsc_pkg.sv =====
package hsc_pkg;

   localparam logic [31:0] C0       = 32'h3633BA63;
   localparam logic [31:0] C1       = 32'hB94FF8AA;
   localparam logic [31:0] C2       = 32'h3C08886F;
   localparam logic [31:0] C3       = 32'hBE2AAAAB;
   localparam logic [31:0] INV_TAU  = 32'h3E22F983;
   localparam logic [31:0] TAU      = 32'h40C90FDB;
   localparam logic [31:0] INV_PIO2 = 32'h3F22F983;
   localparam logic [31:0] PIO2     = 32'h3FC90FDB;

   localparam logic [15:0] HALF_NAN_CODE = 16'h7C01;
   localparam logic [15:0] HALF_INF_BITS = 16'h7C00;
   localparam logic [15:0] HALF_SIGN_BIT = 16'h8000;
   localparam logic [15:0] HALF_MAG_MASK = 16'h7FFF;

   localparam int RED_DEPTH  = 10;
   localparam int POLY_DEPTH = 9;

   typedef struct packed {
      logic nan;
      logic ssign;
      logic csign;
   } side_type;

   function automatic logic [31:0] fneg(logic [31:0] a);
      return {~a[31], a[30:0]};
   endfunction

   function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
      logic        sr;
      logic [47:0] p;
      logic [10:0] e;
      logic [23:0] mr;
      logic        g;
      logic        st;
      logic [24:0] rnd;
      sr = a[31] ^ b[31];
      p  = {1'b1, a[22:0]} * {1'b1, b[22:0]};
      if (p[47]) begin
         mr = p[47:24];
         g  = p[23];
         st = |p[22:0];
         e  = 11'(a[30:23]) + 11'(b[30:23]) - 11'd126;
      end else begin
         mr = p[46:23];
         g  = p[22];
         st = |p[21:0];
         e  = 11'(a[30:23]) + 11'(b[30:23]) - 11'd127;
      end
      rnd = {1'b0, mr} + 25'(g && (st || mr[0]));
      if (rnd[24]) begin
         rnd = rnd >> 1;
         e   = e + 11'd1;
      end
      if (a[30:23] == 8'd0 || b[30:23] == 8'd0 || e[10] || e == 11'd0) begin
         return {sr, 31'd0};
      end
      return {sr, e[7:0], rnd[22:0]};
   endfunction

   function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
      logic [31:0] big;
      logic [31:0] sml;
      logic [26:0] mbig;
      logic [26:0] msml;
      logic [26:0] al;
      logic [26:0] n;
      logic [7:0]  d;
      logic [27:0] sum;
      logic [9:0]  e;
      logic [4:0]  lz;
      logic [23:0] mr;
      logic        g;
      logic        st;
      logic [24:0] rnd;
      if (a[30:23] == 8'd0 && b[30:23] == 8'd0) begin
         return {a[31] & b[31], 31'd0};
      end
      if (b[30:23] == 8'd0) begin
         return a;
      end
      if (a[30:23] == 8'd0) begin
         return b;
      end
      if (a[30:0] >= b[30:0]) begin
         big = a;
         sml = b;
      end else begin
         big = b;
         sml = a;
      end
      mbig = {1'b1, big[22:0], 3'b000};
      msml = {1'b1, sml[22:0], 3'b000};
      d    = big[30:23] - sml[30:23];
      if (d >= 8'd27) begin
         al = 27'd1;
      end else begin
         al    = msml >> d;
         al[0] = al[0] | (|(msml & ((27'd1 << d) - 27'd1)));
      end
      if (big[31] ^ sml[31]) begin
         sum = {1'b0, mbig} - {1'b0, al};
      end else begin
         sum = {1'b0, mbig} + {1'b0, al};
      end
      if (sum == 28'd0) begin
         return 32'd0;
      end
      e = {2'b00, big[30:23]};
      if (sum[27]) begin
         n    = sum[27:1];
         n[0] = n[0] | sum[0];
         e    = e + 10'd1;
      end else begin
         n  = sum[26:0];
         lz = 5'd0;
         for (int i = 0; i < 27; i++) begin
            if (n[i]) begin
               lz = 5'(26 - i);
            end
         end
         n = n << lz;
         e = e - 10'(lz);
      end
      mr  = n[26:3];
      g   = n[2];
      st  = n[1] | n[0];
      rnd = {1'b0, mr} + 25'(g && (st || mr[0]));
      if (rnd[24]) begin
         rnd = rnd >> 1;
         e   = e + 10'd1;
      end
      if (e[9] || e == 10'd0) begin
         return {big[31], 31'd0};
      end
      return {big[31], e[7:0], rnd[22:0]};
   endfunction

   function automatic logic [15:0] ftrunc(logic [31:0] f);
      logic [23:0] v;
      logic [7:0]  sh;
      if (f[31] || f[30:23] < 8'd127) begin
         return 16'd0;
      end
      if (f[30:23] >= 8'd143) begin
         return 16'hFFFF;
      end
      sh = 8'd150 - f[30:23];
      v  = {1'b1, f[22:0]} >> sh;
      return v[15:0];
   endfunction

   function automatic logic [31:0] i2f(logic [15:0] v);
      logic [3:0]  lz;
      logic [15:0] n;
      logic [7:0]  e;
      if (v == 16'd0) begin
         return 32'd0;
      end
      lz = 4'd0;
      for (int i = 0; i < 16; i++) begin
         if (v[i]) begin
            lz = 4'(15 - i);
         end
      end
      n = v << lz;
      e = 8'd142 - 8'(lz);
      return {1'b0, e, n[14:0], 8'd0};
   endfunction

   function automatic logic [31:0] h2f(logic [14:0] h);
      logic [3:0] lz;
      logic [9:0] m;
      logic [7:0] e;
      if (h[14:10] != 5'd0) begin
         return {1'b0, 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
      end
      if (h[9:0] == 10'd0) begin
         return 32'd0;
      end
      lz = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (h[i]) begin
            lz = 4'(9 - i);
         end
      end
      m = h[9:0] << (lz + 4'd1);
      e = 8'd112 - 8'(lz);
      return {1'b0, e, m, 13'd0};
   endfunction

   function automatic logic [15:0] f2h(logic [31:0] f);
      logic               sgn;
      logic signed [9:0]  he;
      logic [9:0]         sh;
      logic [24:0]        full;
      logic [24:0]        r;
      logic [24:0]        rem;
      logic [24:0]        half;
      sgn = f[31];
      if (f[30:23] == 8'hFF) begin
         return {sgn, (f[22:0] != 23'd0) ? 15'h7E00 : HALF_INF_BITS[14:0]};
      end
      he = $signed({2'b00, f[30:23]}) - 10'sd112;
      if (he >= 10'sd31) begin
         return {sgn, HALF_INF_BITS[14:0]};
      end
      if (he <= 10'sd0) begin
         full = {1'b0, 1'b1, f[22:0]};
         sh   = 10'd14 - he;
         if (f[30:23] == 8'd0 || sh > 10'd24) begin
            return {sgn, 15'd0};
         end
         r    = full >> sh;
         rem  = full & ((25'd1 << sh) - 25'd1);
         half = 25'd1 << (sh - 10'd1);
      end else begin
         r    = {10'd0, he[4:0], f[22:13]};
         rem  = {12'd0, f[12:0]};
         half = 25'h1000;
      end
      if (rem > half || (rem == half && r[0])) begin
         r = r + 25'd1;
      end
      return {sgn, r[14:0]};
   endfunction

endpackage

// ===== hdl/half_float_sine_cosine.sv =====
// Throughput: one transaction per cycle; each pipeline stage holds at most one
// binary32 multiply or add, one format conversion, or a truncation to integer
// with its conversion back to binary32, and the whole pipeline holds while
// rsp_stall keeps a result waiting.
// Reset: synchronous, active high; clears all valid bits, data is not reset.
module half_float_sine_cosine import hsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_angle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_sine_value,
   output logic [15:0] rsp_cosine_value
);

   logic        adv;
   logic        red_valid;
   logic [31:0] sin_arg, cos_arg, sin_poly, cos_poly;
   side_type    red_side;
   side_type    side_ff [POLY_DEPTH];
   logic [POLY_DEPTH-1:0] vld_ff;
   logic        rsp_valid_ff;
   logic [15:0] sine_ff, cosine_ff;
   side_type    last_side;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   hsc_reduce u_reduce (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_angle    (req_angle),
      .out_valid   (red_valid),
      .out_sin_arg (sin_arg),
      .out_cos_arg (cos_arg),
      .out_side    (red_side)
   );

   hsc_poly u_poly_sin (
      .clock     (clock),
      .adv       (adv),
      .in_arg    (sin_arg),
      .out_value (sin_poly)
   );

   hsc_poly u_poly_cos (
      .clock     (clock),
      .adv       (adv),
      .in_arg    (cos_arg),
      .out_value (cos_poly)
   );

   assign last_side = side_ff[POLY_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[POLY_DEPTH-2:0], red_valid};
         rsp_valid_ff <= vld_ff[POLY_DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= red_side;
         for (int i = 1; i < POLY_DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         if (last_side.nan) begin
            sine_ff   <= HALF_NAN_CODE;
            cosine_ff <= HALF_NAN_CODE;
         end else begin
            sine_ff   <= f2h(sin_poly) | {last_side.ssign, 15'd0};
            cosine_ff <= f2h(cos_poly) | {last_side.csign, 15'd0};
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sine_value   = sine_ff;
   assign rsp_cosine_value = cosine_ff;

endmodule

// ===== hdl/hsc_reduce.sv =====
module hsc_reduce import hsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [15:0] in_angle,
   output logic        out_valid,
   output logic [31:0] out_sin_arg,
   output logic [31:0] out_cos_arg,
   output side_type    out_side
);

   logic [RED_DEPTH-1:0] vld_ff;
   logic [RED_DEPTH-2:0] nan_ff;
   logic [RED_DEPTH-2:0] sgn_ff;
   logic [31:0] m1_ff, m2_ff, m3_ff, m4_ff, m5_ff, m6_ff, m7_ff, m8_ff, m9_ff;
   logic [31:0] t2_ff, t3_ff, t4_ff, t6_ff, t7_ff, t8_ff;
   logic [1:0]  q7_ff, q8_ff, q9_ff;
   logic        qok7_ff, qok8_ff, qok9_ff;
   logic [31:0] sarg_ff, carg_ff;
   side_type    side_ff;
   logic [15:0] qi;
   logic [31:0] refl;

   assign qi   = ftrunc(t6_ff);
   assign refl = fadd(PIO2, fneg(m9_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[RED_DEPTH-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nan_ff  <= {nan_ff[RED_DEPTH-3:0], in_angle[14:0] >= HALF_INF_BITS[14:0]};
         sgn_ff  <= {sgn_ff[RED_DEPTH-3:0], in_angle[15]};
         m1_ff   <= h2f(in_angle[14:0]);
         t2_ff   <= fmul(INV_TAU, m1_ff);
         m2_ff   <= m1_ff;
         t3_ff   <= i2f(ftrunc(t2_ff));
         m3_ff   <= m2_ff;
         t4_ff   <= fmul(t3_ff, TAU);
         m4_ff   <= m3_ff;
         m5_ff   <= fadd(m4_ff, fneg(t4_ff));
         t6_ff   <= fmul(m5_ff, INV_PIO2);
         m6_ff   <= m5_ff;
         q7_ff   <= qi[1:0];
         qok7_ff <= (qi[15:2] == 14'd0);
         t7_ff   <= i2f(qi);
         m7_ff   <= m6_ff;
         t8_ff   <= fmul(PIO2, t7_ff);
         m8_ff   <= m7_ff;
         q8_ff   <= q7_ff;
         qok8_ff <= qok7_ff;
         m9_ff   <= fadd(m8_ff, fneg(t8_ff));
         q9_ff   <= q8_ff;
         qok9_ff <= qok8_ff;
         sarg_ff <= (qok9_ff && q9_ff[0]) ? refl : m9_ff;
         carg_ff <= (qok9_ff && !q9_ff[0]) ? refl : m9_ff;
         side_ff.nan   <= nan_ff[RED_DEPTH-2];
         side_ff.ssign <= sgn_ff[RED_DEPTH-2] ^ (qok9_ff && q9_ff[1]);
         side_ff.csign <= qok9_ff && (q9_ff[0] ^ q9_ff[1]);
      end
   end

   assign out_valid   = vld_ff[RED_DEPTH-1];
   assign out_sin_arg = sarg_ff;
   assign out_cos_arg = carg_ff;
   assign out_side    = side_ff;

endmodule

// ===== hdl/hsc_poly.sv =====
module hsc_poly import hsc_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] in_arg,
   output logic [31:0] out_value
);

   logic [31:0] a1_ff, a2_ff, a3_ff, a4_ff, a5_ff, a6_ff, a7_ff, a8_ff;
   logic [31:0] x21_ff, x22_ff, x23_ff, x24_ff, x25_ff;
   logic [31:0] x32_ff, x33_ff, x34_ff, x35_ff, x36_ff, x37_ff;
   logic [31:0] p2_ff, p3_ff, p4_ff, p5_ff, p6_ff, p7_ff;
   logic [31:0] t8_ff, r9_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= in_arg;
         x21_ff <= fmul(in_arg, in_arg);
         a2_ff  <= a1_ff;
         x22_ff <= x21_ff;
         x32_ff <= fmul(x21_ff, a1_ff);
         p2_ff  <= fmul(C0, x21_ff);
         a3_ff  <= a2_ff;
         x23_ff <= x22_ff;
         x33_ff <= x32_ff;
         p3_ff  <= fadd(p2_ff, C1);
         a4_ff  <= a3_ff;
         x24_ff <= x23_ff;
         x34_ff <= x33_ff;
         p4_ff  <= fmul(p3_ff, x23_ff);
         a5_ff  <= a4_ff;
         x25_ff <= x24_ff;
         x35_ff <= x34_ff;
         p5_ff  <= fadd(p4_ff, C2);
         a6_ff  <= a5_ff;
         x36_ff <= x35_ff;
         p6_ff  <= fmul(p5_ff, x25_ff);
         a7_ff  <= a6_ff;
         x37_ff <= x36_ff;
         p7_ff  <= fadd(p6_ff, C3);
         a8_ff  <= a7_ff;
         t8_ff  <= fmul(x37_ff, p7_ff);
         r9_ff  <= fadd(a8_ff, t8_ff);
      end
   end

   assign out_value = r9_ff;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import hsc_pkg::*;

   typedef struct {
      logic [15:0] sine;
      logic [15:0] cosine;
   } trig_pair_type;

   class trig_scoreboard_type;
      trig_pair_type awaited[$];
      int            failures;

      function logic [31:0] pack_round(logic sgn, logic [319:0] mant, int w);
         int           p;
         int           sh;
         logic [319:0] q;
         logic [319:0] rem;
         logic [319:0] halfw;
         if (mant == 0) return {sgn, 31'd0};
         p = 0;
         for (int i = 0; i < 320; i++) if (mant[i]) p = i;
         sh = p - 23;
         if (w + sh < -149) sh = -149 - w;
         if (sh > 0) begin
            q     = mant >> sh;
            rem   = mant & ((320'd1 << sh) - 320'd1);
            halfw = 320'd1 << (sh - 1);
            if (rem > halfw || (rem == halfw && q[0])) q = q + 320'd1;
         end else begin
            q = mant << (-sh);
         end
         w = w + sh;
         if (q[24]) begin
            q = q >> 1;
            w = w + 1;
         end
         if (!q[23]) return {sgn, 8'd0, q[22:0]};
         if (w + 150 >= 255) return {sgn, 8'hFF, 23'd0};
         return {sgn, 8'(w + 150), q[22:0]};
      endfunction

      function void split(logic [31:0] f, output logic s, output logic [319:0] m,
                          output int w);
         s = f[31];
         if (f[30:23] == 8'd0) begin
            m = 320'(f[22:0]);
            w = -149;
         end else begin
            m = 320'({1'b1, f[22:0]});
            w = int'(f[30:23]) - 150;
         end
      endfunction

      function logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
         logic         sa, sb;
         logic [319:0] ma, mb;
         int           wa, wb;
         split(a, sa, ma, wa);
         split(b, sb, mb, wb);
         return pack_round(sa ^ sb, ma * mb, wa + wb);
      endfunction

      function logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
         logic         sa, sb;
         logic [319:0] ma, mb;
         int           wa, wb, lo;
         split(a, sa, ma, wa);
         split(b, sb, mb, wb);
         if (ma == 0 && mb == 0) return {sa & sb, 31'd0};
         lo = (wa < wb) ? wa : wb;
         ma = ma << (wa - lo);
         mb = mb << (wb - lo);
         if (sa == sb) return pack_round(sa, ma + mb, lo);
         if (ma == mb) return 32'd0;
         if (ma > mb) return pack_round(sa, ma - mb, lo);
         return pack_round(sb, mb - ma, lo);
      endfunction

      function logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
         return fadd(a, {~b[31], b[30:0]});
      endfunction

      function int trunc_int(logic [31:0] f);
         int mag;
         if (f[30:23] < 8'd127) return 0;
         if (f[30:23] >= 8'd150) mag = int'({1'b1, f[22:0]}) << (f[30:23] - 150);
         else mag = int'({1'b1, f[22:0]}) >> (150 - f[30:23]);
         return f[31] ? -mag : mag;
      endfunction

      function logic [31:0] int_to_float(int v);
         return pack_round(v < 0, 320'((v < 0) ? -v : v), 0);
      endfunction

      function logic [15:0] narrow(logic [31:0] f);
         logic [15:0] sgn;
         int          e, he, sh;
         logic [31:0] m, full, r, rem, halfw;
         sgn = f[31] ? HALF_SIGN_BIT : 16'd0;
         e   = int'(f[30:23]);
         m   = 32'(f[22:0]);
         if (e == 255) return sgn | ((m != 0) ? 16'h7E00 : HALF_INF_BITS);
         he = e - 112;
         if (he >= 31) return sgn | HALF_INF_BITS;
         if (he <= 0) begin
            full = m | 32'h800000;
            sh   = 14 - he;
            if (e == 0 || sh > 24) return sgn;
            r     = full >> sh;
            rem   = full & ((32'd1 << sh) - 32'd1);
            halfw = 32'd1 << (sh - 1);
         end else begin
            r     = (32'(he) << 10) | (m >> 13);
            rem   = m & 32'h1FFF;
            halfw = 32'h1000;
         end
         if (rem > halfw || (rem == halfw && r[0])) r = r + 32'd1;
         return sgn | (r[15:0] & HALF_MAG_MASK);
      endfunction

      function logic [31:0] odd_series(logic [31:0] a);
         logic [31:0] x2, x3, p;
         x2 = fmul(a, a);
         x3 = fmul(x2, a);
         p  = fmul(C0, x2);
         p  = fadd(p, C1);
         p  = fmul(p, x2);
         p  = fadd(p, C2);
         p  = fmul(p, x2);
         p  = fadd(p, C3);
         return fadd(a, fmul(x3, p));
      endfunction

      function trig_pair_type sincos(logic [15:0] x);
         trig_pair_type res;
         logic [31:0]   m, t, s, c;
         logic [4:0]    ex;
         int            q;
         logic          ssign, csign;
         if ((x & HALF_MAG_MASK) >= HALF_INF_BITS) begin
            res.sine   = HALF_NAN_CODE;
            res.cosine = HALF_NAN_CODE;
            return res;
         end
         ex = x[14:10];
         m  = pack_round(1'b0, 320'({ex != 5'd0, x[9:0]}), (ex != 5'd0) ? int'(ex) - 25 : -24);
         t  = fmul(INV_TAU, m);
         t  = int_to_float(trunc_int(t));
         t  = fmul(t, TAU);
         m  = fsub(m, t);
         t  = fmul(m, INV_PIO2);
         q  = trunc_int(t);
         t  = fmul(PIO2, int_to_float(q));
         m  = fsub(m, t);
         ssign = x[15] ^ (q == 2 || q == 3);
         s     = odd_series((q == 1 || q == 3) ? fsub(PIO2, m) : m);
         csign = (q == 1 || q == 2);
         c     = odd_series((q == 0 || q == 2) ? fsub(PIO2, m) : m);
         res.sine   = narrow(s) | {ssign, 15'd0};
         res.cosine = narrow(c) | {csign, 15'd0};
         return res;
      endfunction

      function void note_angle(logic [15:0] x);
         awaited.push_back(sincos(x));
      endfunction

      function void check_result(logic [15:0] sine, logic [15:0] cosine);
         trig_pair_type exp_pair;
         if (awaited.size() == 0) begin
            $display("%0t: unexpected result sine %h cosine %h", $time, sine, cosine);
            failures++;
            return;
         end
         exp_pair = awaited.pop_front();
         if (sine !== exp_pair.sine) begin
            $display("%0t: sine expected %h actual %h", $time, exp_pair.sine, sine);
            failures++;
         end
         if (cosine !== exp_pair.cosine) begin
            $display("%0t: cosine expected %h actual %h", $time, exp_pair.cosine, cosine);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_angle;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_sine_value;
   logic [15:0] rsp_cosine_value;

   trig_scoreboard_type book;
   int idle_pct;
   int stall_pct;
   int hold_left;
   int quiet_cycles;

   half_float_sine_cosine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_angle(req_angle),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_sine_value(rsp_sine_value),
      .rsp_cosine_value(rsp_cosine_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left = hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_result(rsp_sine_value, rsp_cosine_value);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_angle(input logic [15:0] a);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= a;
      do @(posedge clock); while (req_stall);
      book.note_angle(a);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_angle();
      if ($urandom_range(9) < 7) return {1'($urandom), 5'($urandom_range(29)), 10'($urandom)};
      return 16'($urandom);
   endfunction

   task automatic run_phase(input int idle_p, input int stall_p, input int count);
      idle_pct  = idle_p;
      stall_pct = stall_p;
      repeat (count) send_angle(random_angle());
   endtask

   initial begin
      logic [15:0] directed[$];
      book         = new();
      idle_pct     = 0;
      stall_pct    = 0;
      hold_left    = 0;
      quiet_cycles = 0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_angle    = 16'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF, 16'h0400, 16'h3C00,
                   16'h3E48, 16'hBE48, 16'h4248, 16'h4648, 16'hC648, 16'h4000, 16'h4500,
                   16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'h7E00, 16'hFFFF,
                   16'h2E66, 16'h5A48};
      foreach (directed[i]) send_angle(directed[i]);

      run_phase(0, 0, 130);
      run_phase(62, 0, 130);
      wait_drained();
      hold_left = 300;
      run_phase(0, 0, 60);
      run_phase(0, 62, 130);
      run_phase(21, 21, 130);
      wait_drained();
      repeat (40) @(posedge clock);

      if (book.failures == 0 && book.awaited.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
